>>> rtl/tslw_pkg.sv
// Shared types, constants and a lookup function for the three-digit LCD segment writer.
// Used by every module in rtl/; depends on nothing else.
package tslw_pkg;

  // Request codes.
  localparam logic [1:0] CMD_DISPLAY = 2'd0;
  localparam logic [1:0] CMD_CONTROL = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // Job kinds passed from the front to the back.
  localparam logic [1:0] JOB_CONTROL = 2'd0;
  localparam logic [1:0] JOB_CLEAR   = 2'd1;
  localparam logic [1:0] JOB_DISPLAY = 2'd2;

  localparam logic [2:0] HDR_COMMAND = 3'b100;
  localparam logic [2:0] HDR_WRITE   = 3'b101;
  localparam logic [3:0] LEN_COMMAND = 4'd12;
  localparam logic [3:0] LEN_WRITE   = 4'd13;

  localparam int MEMORY_NIBBLES = 32;
  localparam int MAX_RESULTS    = 32;
  localparam int IDX_W          = $clog2(MAX_RESULTS);
  localparam int CLEAR_FRAMES   =
    (MEMORY_NIBBLES > MAX_RESULTS) ? MAX_RESULTS : MEMORY_NIBBLES;
  localparam logic [IDX_W-1:0] CLEAR_LAST    = IDX_W'(CLEAR_FRAMES - 1);
  localparam logic [IDX_W-1:0] DISPLAY_LAST  = IDX_W'(5);

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] command;
    logic       side;
    logic [9:0] value;
    logic [7:0] controller_command;
  } in_t;

  typedef struct packed {
    logic [12:0] frame_bits;
    logic [3:0]  frame_length;
    logic        is_last;
  } out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic [2:0] base;
    logic [7:0] seg_hundreds;
    logic [7:0] seg_tens;
    logic [7:0] seg_ones;
  } job_t;

  // Segment byte for one decimal digit.
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] s;
    case (digit)
      4'd0:    s = 8'hD7;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'hE3;
      4'd3:    s = 8'hA7;
      4'd4:    s = 8'h36;
      4'd5:    s = 8'hB5;
      4'd6:    s = 8'hF5;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'hF7;
      4'd9:    s = 8'hB7;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/tslw_front.sv
// Request classifier: splits a display value into digits and segment bytes.
// Depends on tslw_pkg.
module tslw_front
  import tslw_pkg::*;
(
  input  in_t  req,
  output job_t job,
  output logic keep
);

  logic [3:0] hund;
  logic [3:0] tens;
  logic [3:0] ones;
  logic [6:0] rem_h;

  // Digits by threshold compares; every threshold is a constant.
  always_comb begin
    hund = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (req.value >= 10'(k * 100)) begin
        hund = 4'(k);
      end
    end
    rem_h = 7'(req.value - 10'(int'(hund) * 100));
    tens = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_h >= 7'(k * 10)) begin
        tens = 4'(k);
      end
    end
    ones = 4'(rem_h - 7'(int'(tens) * 10));
  end

  always_comb begin
    job.code         = req.controller_command;
    job.base         = req.side ? 3'd0 : 3'd3;
    job.seg_hundreds = (hund != 4'd0) ? seg_of(hund) : 8'h00;
    if (tens != 4'd0) begin
      job.seg_tens = seg_of(tens);
    end else if (hund != 4'd0) begin
      job.seg_tens = seg_of(4'd0);
    end else begin
      job.seg_tens = 8'h00;
    end
    job.seg_ones = seg_of(ones);
    case (req.command)
      CMD_DISPLAY: begin
        job.kind = JOB_DISPLAY;
        keep     = (req.value <= 10'd999);
      end
      CMD_CONTROL: begin
        job.kind = JOB_CONTROL;
        keep     = 1'b1;
      end
      CMD_CLEAR: begin
        job.kind = JOB_CLEAR;
        keep     = 1'b1;
      end
      default: begin
        job.kind = JOB_CONTROL;
        keep     = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/tslw_queue.sv
// Short job queue between the classifier and the frame sequencer.
// Depends on tslw_pkg.
module tslw_queue
  import tslw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_job,
  output logic q_full,
  output logic q_valid,
  output job_t rd_job,
  input  logic rd_en
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign rd_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

>>> rtl/tslw_back.sv
// Frame sequencer: turns a queued job into frames, one per cycle unless stalled.
// Depends on tslw_pkg.
module tslw_back
  import tslw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  job_t q_job,
  output logic q_pop,
  output logic out_valid,
  output out_t out_frame,
  input  logic pop
);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_frame_r, out_frame_nxt;
  out_t             frame;
  logic             adv;
  logic [1:0]       digit;
  logic [2:0]       pos;
  logic [7:0]       seg;
  logic [3:0]       nib;

  assign adv   = q_valid && (!out_valid_r || pop);
  assign q_pop = adv && frame.is_last;

  always_comb begin
    digit = idx_r[2:1];
    pos   = q_job.base + 3'd2 - {1'b0, digit};
    case (digit)
      2'd0:    seg = q_job.seg_hundreds;
      2'd1:    seg = q_job.seg_tens;
      default: seg = q_job.seg_ones;
    endcase
    nib = idx_r[0] ? seg[7:4] : seg[3:0];
    case (q_job.kind)
      JOB_CONTROL: begin
        frame.frame_bits   = {1'b0, HDR_COMMAND, q_job.code, 1'b0};
        frame.frame_length = LEN_COMMAND;
        frame.is_last      = 1'b1;
      end
      JOB_CLEAR: begin
        frame.frame_bits   = {HDR_WRITE, 6'(idx_r), 4'd0};
        frame.frame_length = LEN_WRITE;
        frame.is_last      = (idx_r == CLEAR_LAST);
      end
      JOB_DISPLAY: begin
        frame.frame_bits   = {HDR_WRITE, 2'b00, pos, idx_r[0], nib};
        frame.frame_length = LEN_WRITE;
        frame.is_last      = (idx_r == DISPLAY_LAST);
      end
      default: begin
        frame.frame_bits   = '0;
        frame.frame_length = LEN_COMMAND;
        frame.is_last      = 1'b1;
      end
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_frame_nxt = out_frame_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_frame_nxt = frame;
      idx_nxt       = frame.is_last ? '0 : idx_r + 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_frame_r <= out_frame_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_frame = out_frame_r;

`ifndef NO_ASSERTIONS
  // A job in progress keeps its queue entry until its final frame is registered.
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> q_valid)
    else $error("sequencer mid-job without a queued job");

  // The queue head is released only while it is present.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // Command frames are always the only frame of their request.
  a_cmd_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_r.frame_length == LEN_COMMAND) |-> out_frame_r.is_last)
    else $error("command frame not marked last");

  // Write frames always carry the write header.
  a_write_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_r.frame_length == LEN_WRITE)
      |-> (out_frame_r.frame_bits[12:10] == HDR_WRITE))
    else $error("write frame with wrong header");

  // The index advances only while the output stage takes a new frame.
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv) |=> $stable(idx_r))
    else $error("frame index moved without a frame");
`endif

endmodule

>>> rtl/three_digit_lcd_segment_writer.sv
// A request accepted while the sequencer is idle is queued; its first frame reaches
// the result ports once the output register has loaded it, and can then be popped.
// One frame per cycle while the output register is free or popped; a controller
// command yields 1 frame, a display value 6 and a clear 32 via the single output.
// Dropped requests (display value above 999, unused code) take no sequencer time.
// Reset (rst_n low, synchronous) empties the job queue and the output register.
module three_digit_lcd_segment_writer
  import tslw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  in_t  in_req,
  output logic empty,
  input  logic pop,
  output out_t out_frame
);

  // The front classifies each request combinationally: it decodes the request,
  // drops requests that produce no frames, and precomputes the three segment
  // bytes of a display value so that the back needs no digit arithmetic.
  job_t front_job;
  logic front_keep;

  // The queue decouples acceptance from frame generation, so a new request is
  // taken while earlier ones are still being turned into frames.
  logic q_full;
  logic q_valid;
  logic q_pop;
  job_t q_job;
  logic out_valid;

  tslw_front u_front (
    .req  (in_req),
    .job  (front_job),
    .keep (front_keep)
  );

  // A request is accepted whenever the queue has room; a request that yields
  // no frames is accepted and simply not stored.
  tslw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push && !q_full && front_keep),
    .wr_job  (front_job),
    .q_full  (q_full),
    .q_valid (q_valid),
    .rd_job  (q_job),
    .rd_en   (q_pop)
  );

  // The back walks each job one frame per cycle, while the output is free or popped,
  // into an output register that refills in the same cycle it is popped.
  tslw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_frame (out_frame),
    .pop       (pop)
  );

  assign full  = q_full;
  assign empty = !out_valid;

endmodule
